[rtl/csvtok_pkg.sv]
// ----------------------------------------------------------------------------
// csvtok_pkg
// Types and constants shared by the CSV record tokenizer modules.
// ----------------------------------------------------------------------------
package csvtok_pkg;

  localparam int CHAR_W    = 16;
  localparam int FIELD_W   = 9;
  localparam int LINE_W    = 24;
  localparam int COL_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CHAR_W-1:0] CH_QUOTE    = 16'h0022;
  localparam logic [CHAR_W-1:0] CH_CR       = 16'h000D;
  localparam logic [CHAR_W-1:0] CH_LF       = 16'h000A;
  localparam logic [CHAR_W-1:0] DEFAULT_SEP = 16'h002C;

  localparam logic [LINE_W-1:0]  LINE_RESET      = 24'd2;
  localparam logic [FIELD_W-1:0] EXPECTED_RESET  = 9'd0;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED  = 2'd1;

  typedef enum logic [2:0] {
    PH_BETWEEN,
    PH_QUOTED,
    PH_AFTER_QUOTE,
    PH_UNQUOTED,
    PH_AFTER_CR,
    PH_FAILED
  } phase_e;

  typedef enum logic [2:0] {
    KIND_CHAR   = 3'd0,
    KIND_FIELD  = 3'd1,
    KIND_RECORD = 3'd2,
    KIND_ERROR  = 3'd3,
    KIND_END    = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ERR_QUOTE_UNQUOTED = 2'd0,
    ERR_AFTER_QUOTE    = 2'd1,
    ERR_CR_NO_LF       = 2'd2,
    ERR_EARLY_END      = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_CHAR,
    ACT_FIELD,
    ACT_RECORD,
    ACT_FAIL,
    ACT_END
  } act_e;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              at_end;
  } in_t;

  typedef struct packed {
    kind_e              kind;
    logic [CHAR_W-1:0]  out_char;
    logic [FIELD_W-1:0] field_index;
    logic               count_ok;
    logic               blank_line;
    err_e               error_code;
    logic [LINE_W-1:0]  line_no;
    logic [COL_W-1:0]   column_no;
  } out_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  separator;
    logic [FIELD_W-1:0] expected_fields;
  } cfg_t;

  // beat held in the input register
  typedef struct packed {
    logic valid;
    in_t  data;
  } in_beat_t;

  // result of one parse step
  typedef struct packed {
    logic valid;
    out_t data;
  } res_beat_t;

endpackage

[rtl/csvtok_in_stage.sv]
// ----------------------------------------------------------------------------
// csvtok_in_stage
// Input register: holds one beat until the parse step consumes it.
// ----------------------------------------------------------------------------
module csvtok_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  csvtok_pkg::in_t     in_data_i,
  input  logic                adv_i,
  output csvtok_pkg::in_beat_t beat_o
);

  logic            valid_q, valid_d;
  csvtok_pkg::in_t data_q;
  logic            load;

  assign in_ready_o = !valid_q || adv_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

  assign beat_o.valid = valid_q;
  assign beat_o.data  = data_q;

endmodule

[rtl/csvtok_parse.sv]
// ----------------------------------------------------------------------------
// csvtok_parse
// Parse state and the combinational step that turns one beat into at most
// one result.
// ----------------------------------------------------------------------------
module csvtok_parse #(
  parameter int MAX_FIELDS = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  csvtok_pkg::cfg_t      cfg_i,
  input  csvtok_pkg::in_t       item_i,
  input  logic                  adv_i,
  output csvtok_pkg::res_beat_t res_o
);

  localparam logic [csvtok_pkg::FIELD_W-1:0] FIELD_CAP =
    csvtok_pkg::FIELD_W'((MAX_FIELDS < 511) ? MAX_FIELDS : 511);

  csvtok_pkg::phase_e                phase_q, phase_d, phase_nx;
  logic [csvtok_pkg::FIELD_W-1:0]    fc_q, fc_d, fc_inc;
  logic                              ne_q, ne_d;
  logic [csvtok_pkg::LINE_W-1:0]     line_q, line_d, line_inc;
  logic [csvtok_pkg::COL_W-1:0]      col_q, col_d, col_inc;

  csvtok_pkg::act_e act;
  csvtok_pkg::err_e err;
  logic             is_sep, is_quote, is_cr, is_lf;
  logic             rec_ok, rec_blank;

  assign is_sep   = item_i.ch == cfg_i.separator;
  assign is_quote = item_i.ch == csvtok_pkg::CH_QUOTE;
  assign is_cr    = item_i.ch == csvtok_pkg::CH_CR;
  assign is_lf    = item_i.ch == csvtok_pkg::CH_LF;

  assign col_inc  = (col_q != '1) ? col_q + 1'b1 : col_q;
  assign line_inc = (line_q != '1) ? line_q + 1'b1 : line_q;
  assign fc_inc   = (fc_q < FIELD_CAP) ? fc_q + 1'b1 : fc_q;

  assign rec_blank = (fc_q == '0) && !ne_q;

  always_comb begin
    if (cfg_i.expected_fields == '0) begin
      rec_ok = 1'b1;
    end else if (fc_q >= FIELD_CAP) begin
      rec_ok = 1'b0;
    end else begin
      rec_ok = ({1'b0, fc_q} + 1'b1) == {1'b0, cfg_i.expected_fields};
    end
  end

  // pick the action for this beat, order of tests follows the phase
  always_comb begin
    act      = csvtok_pkg::ACT_NONE;
    err      = csvtok_pkg::ERR_QUOTE_UNQUOTED;
    phase_nx = phase_q;
    if (item_i.at_end) begin
      priority if (phase_q == csvtok_pkg::PH_QUOTED ||
                   phase_q == csvtok_pkg::PH_AFTER_CR) begin
        act = csvtok_pkg::ACT_FAIL;
        err = csvtok_pkg::ERR_EARLY_END;
      end else if (phase_q == csvtok_pkg::PH_UNQUOTED ||
                   phase_q == csvtok_pkg::PH_AFTER_QUOTE ||
                   (phase_q == csvtok_pkg::PH_BETWEEN && fc_q != '0)) begin
        act = csvtok_pkg::ACT_RECORD;
      end else begin
        act = csvtok_pkg::ACT_END;
      end
    end else begin
      unique case (phase_q)
        csvtok_pkg::PH_BETWEEN: begin
          priority if (is_cr) begin
            phase_nx = csvtok_pkg::PH_AFTER_CR;
          end else if (is_lf) begin
            act = csvtok_pkg::ACT_RECORD;
          end else if (is_sep) begin
            act = csvtok_pkg::ACT_FIELD;
          end else if (is_quote) begin
            phase_nx = csvtok_pkg::PH_QUOTED;
          end else begin
            phase_nx = csvtok_pkg::PH_UNQUOTED;
            act      = csvtok_pkg::ACT_CHAR;
          end
        end
        csvtok_pkg::PH_QUOTED: begin
          if (is_quote) begin
            phase_nx = csvtok_pkg::PH_AFTER_QUOTE;
          end else begin
            act = csvtok_pkg::ACT_CHAR;
          end
        end
        csvtok_pkg::PH_AFTER_QUOTE: begin
          priority if (is_sep) begin
            act = csvtok_pkg::ACT_FIELD;
          end else if (is_quote) begin
            // doubled quote inside a quoted field
            phase_nx = csvtok_pkg::PH_QUOTED;
            act      = csvtok_pkg::ACT_CHAR;
          end else if (is_cr) begin
            phase_nx = csvtok_pkg::PH_AFTER_CR;
          end else if (is_lf) begin
            act = csvtok_pkg::ACT_RECORD;
          end else begin
            act = csvtok_pkg::ACT_FAIL;
            err = csvtok_pkg::ERR_AFTER_QUOTE;
          end
        end
        csvtok_pkg::PH_UNQUOTED: begin
          priority if (is_quote) begin
            act = csvtok_pkg::ACT_FAIL;
            err = csvtok_pkg::ERR_QUOTE_UNQUOTED;
          end else if (is_cr) begin
            phase_nx = csvtok_pkg::PH_AFTER_CR;
          end else if (is_lf) begin
            act = csvtok_pkg::ACT_RECORD;
          end else if (is_sep) begin
            act = csvtok_pkg::ACT_FIELD;
          end else begin
            act = csvtok_pkg::ACT_CHAR;
          end
        end
        csvtok_pkg::PH_AFTER_CR: begin
          if (is_lf) begin
            act = csvtok_pkg::ACT_RECORD;
          end else begin
            act = csvtok_pkg::ACT_FAIL;
            err = csvtok_pkg::ERR_CR_NO_LF;
          end
        end
        default: begin
          act = csvtok_pkg::ACT_NONE;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    phase_d = phase_nx;
    fc_d    = fc_q;
    ne_d    = ne_q;
    line_d  = line_q;
    col_d   = col_q;
    unique case (act)
      csvtok_pkg::ACT_CHAR: begin
        ne_d = 1'b1;
      end
      csvtok_pkg::ACT_FIELD: begin
        fc_d    = fc_inc;
        ne_d    = 1'b0;
        phase_d = csvtok_pkg::PH_BETWEEN;
      end
      csvtok_pkg::ACT_RECORD: begin
        fc_d    = '0;
        ne_d    = 1'b0;
        phase_d = csvtok_pkg::PH_BETWEEN;
      end
      csvtok_pkg::ACT_FAIL: begin
        phase_d = csvtok_pkg::PH_FAILED;
      end
      default: begin
        phase_d = phase_nx;
      end
    endcase
    if (item_i.at_end) begin
      // end marker restarts the parse
      phase_d = csvtok_pkg::PH_BETWEEN;
      fc_d    = '0;
      ne_d    = 1'b0;
      line_d  = csvtok_pkg::LINE_RESET;
      col_d   = '0;
    end else if (is_lf) begin
      line_d = line_inc;
      col_d  = '0;
    end else begin
      col_d = col_inc;
    end
  end

  // result fields
  always_comb begin
    res_o.valid                 = act != csvtok_pkg::ACT_NONE;
    res_o.data.kind             = csvtok_pkg::KIND_END;
    res_o.data.out_char         = '0;
    res_o.data.field_index      = fc_q;
    res_o.data.count_ok         = 1'b0;
    res_o.data.blank_line       = 1'b0;
    res_o.data.error_code       = csvtok_pkg::ERR_QUOTE_UNQUOTED;
    res_o.data.line_no          = line_q;
    res_o.data.column_no        = item_i.at_end ? col_q : col_inc;
    unique case (act)
      csvtok_pkg::ACT_CHAR: begin
        res_o.data.kind     = csvtok_pkg::KIND_CHAR;
        res_o.data.out_char = item_i.ch;
      end
      csvtok_pkg::ACT_FIELD: begin
        res_o.data.kind = csvtok_pkg::KIND_FIELD;
      end
      csvtok_pkg::ACT_RECORD: begin
        res_o.data.kind       = csvtok_pkg::KIND_RECORD;
        res_o.data.count_ok   = rec_ok;
        res_o.data.blank_line = rec_blank;
      end
      csvtok_pkg::ACT_FAIL: begin
        res_o.data.kind       = csvtok_pkg::KIND_ERROR;
        res_o.data.error_code = err;
      end
      default: begin
        res_o.data.kind = csvtok_pkg::KIND_END;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= csvtok_pkg::PH_BETWEEN;
      fc_q    <= '0;
      ne_q    <= 1'b0;
      line_q  <= csvtok_pkg::LINE_RESET;
      col_q   <= '0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      fc_q    <= fc_d;
      ne_q    <= ne_d;
      line_q  <= line_d;
      col_q   <= col_d;
    end
  end

endmodule

[rtl/csvtok_out_stage.sv]
// ----------------------------------------------------------------------------
// csvtok_out_stage
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module csvtok_out_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  csvtok_pkg::res_beat_t res_i,
  input  logic                  adv_i,
  output logic                  free_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output csvtok_pkg::out_t      out_data_o
);

  logic             valid_q, valid_d;
  csvtok_pkg::out_t data_q;
  logic             load;

  assign free_o = !valid_q || out_ready_i;
  assign load   = adv_i && res_i.valid;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= res_i.data;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

[rtl/csv_record_tokenizer_top.sv]
// ----------------------------------------------------------------------------
// csv_record_tokenizer_top
// CSV tokenizer: one UTF-16 character or end marker in, at most one token out.
// ----------------------------------------------------------------------------
// One input beat is taken per cycle unless the result register stalls. A beat
// sits in the input register, the parse step runs on it and its result (if any)
// lands in the result register, from which the sink can take it. The result
// register is the only thing that throttles the rate: the block keeps taking
// one beat per cycle as long as the result register is empty or the sink takes
// its result. Configuration writes are taken at any time with no wait state,
// and should only be issued while the block is idle.
module csv_record_tokenizer_top #(
  parameter int MAX_FIELDS = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  csvtok_pkg::in_t                     in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output csvtok_pkg::out_t                    out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [csvtok_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [csvtok_pkg::CHAR_W-1:0]       cfg_data_i
);

  csvtok_pkg::in_beat_t  in_beat;
  csvtok_pkg::res_beat_t res;
  csvtok_pkg::cfg_t      cfg;
  logic                  out_free;
  logic                  adv;

  logic [csvtok_pkg::CHAR_W-1:0]  sep_q;
  logic [csvtok_pkg::FIELD_W-1:0] exp_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= csvtok_pkg::DEFAULT_SEP;
      exp_q <= csvtok_pkg::EXPECTED_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == csvtok_pkg::REG_SEPARATOR) begin
        sep_q <= cfg_data_i;
      end else if (cfg_index_i == csvtok_pkg::REG_EXPECTED) begin
        exp_q <= cfg_data_i[csvtok_pkg::FIELD_W-1:0];
      end
    end
  end

  assign cfg.separator       = sep_q;
  assign cfg.expected_fields = exp_q;

  // a held beat moves on once the result register can take its result
  assign adv = in_beat.valid && out_free;

  csvtok_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .adv_i      (adv),
    .beat_o     (in_beat)
  );

  csvtok_parse #(
    .MAX_FIELDS (MAX_FIELDS)
  ) u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .item_i (in_beat.data),
    .adv_i  (adv),
    .res_o  (res)
  );

  csvtok_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .adv_i       (adv),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // input side stalls only behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_beat.valid && out_valid_o && !out_ready_i))
    else $error("input stalled without a blocked result");

  // blank record means no field was closed before it
  a_blank_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.blank_line) |->
      (out_data_o.kind == csvtok_pkg::KIND_RECORD && out_data_o.field_index == '0))
    else $error("blank record with nonzero field index");

  // record flags and error code stay clear outside their own kinds
  a_flags_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind != csvtok_pkg::KIND_RECORD &&
     out_data_o.kind != csvtok_pkg::KIND_ERROR) |->
      (!out_data_o.count_ok && !out_data_o.blank_line &&
       out_data_o.error_code == csvtok_pkg::ERR_QUOTE_UNQUOTED))
    else $error("stray flags on a token");

  // a result never appears without a parsed beat the cycle before
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(adv && res.valid))
    else $error("result without a source beat");

endmodule
